@@ hw/rtl/wcmg_pkg.sv @@
// Shared types and constants for the weighted coverage marginal gain unit.
`timescale 1ns / 1ps
`default_nettype none

package wcmg_pkg;

    // Field widths fixed by the stream format
    localparam int KIND_W  = 3;
    localparam int ELEM_W  = 8;
    localparam int ITEM_W  = 8;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;
    localparam int VALUE_W = 32;
    localparam int GAIN_W  = 40;
    localparam int TOTAL_W = 48;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 88;

    // Input word kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_SET_MOD    = 3'd0,
        KIND_SET_WEIGHT = 3'd1,
        KIND_SET_EDGE   = 3'd2,
        KIND_SET_DEGREE = 3'd3,
        KIND_START      = 3'd4,
        KIND_ADD        = 3'd5
    } kind_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_LOAD,
        ST_WALK,
        ST_DRAIN,
        ST_FIN,
        ST_CLEAR
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic wr_mod;
        logic wr_wgt;
        logic wr_edge;
        logic wr_deg;
        logic clr;
        logic clr_wr;
        logic cap;
        logic hdr_ld;
        logic edge_rd;
        logic fin;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic elem_ok;
        logic deg_zero;
        logic walk_last;
        logic pipe_busy;
        logic out_free;
        logic clr_last;
    } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/wcmg_ram.sv @@
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module wcmg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                                     aclk,
    input  wire logic                                     we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/wcmg_ctrl.sv @@
// Controller state machine: sequences loads, start and element adds.
`timescale 1ns / 1ps
`default_nettype none

module wcmg_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire wcmg_pkg::kind_t      kind,
    input  wire wcmg_pkg::sts_t       sts,
    output wcmg_pkg::cmd_t            cmd
);

    wcmg_pkg::state_t state_reg, state_next;
    logic             acc;

    assign s_tready = (state_reg == wcmg_pkg::ST_IDLE);
    assign acc      = s_tvalid && s_tready;

    // State register; reset starts with a pass over the covered marks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wcmg_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            wcmg_pkg::ST_IDLE: begin
                if (acc) begin
                    case (kind)
                        wcmg_pkg::KIND_SET_MOD:    cmd.wr_mod  = 1'b1;
                        wcmg_pkg::KIND_SET_WEIGHT: cmd.wr_wgt  = 1'b1;
                        wcmg_pkg::KIND_SET_EDGE:   cmd.wr_edge = 1'b1;
                        wcmg_pkg::KIND_SET_DEGREE: cmd.wr_deg  = 1'b1;
                        wcmg_pkg::KIND_START: begin
                            cmd.clr    = 1'b1;
                            state_next = wcmg_pkg::ST_CLEAR;
                        end
                        wcmg_pkg::KIND_ADD: begin
                            cmd.cap    = 1'b1;
                            state_next = wcmg_pkg::ST_HDR;
                        end
                        default: ;
                    endcase
                end
            end
            // header reads at the captured element are in flight
            wcmg_pkg::ST_HDR: begin
                state_next = sts.elem_ok ? wcmg_pkg::ST_LOAD : wcmg_pkg::ST_FIN;
            end
            wcmg_pkg::ST_LOAD: begin
                cmd.hdr_ld = 1'b1;
                state_next = sts.deg_zero ? wcmg_pkg::ST_DRAIN : wcmg_pkg::ST_WALK;
            end
            // one neighbour read per cycle
            wcmg_pkg::ST_WALK: begin
                cmd.edge_rd = 1'b1;
                if (sts.walk_last) begin
                    state_next = wcmg_pkg::ST_DRAIN;
                end
            end
            wcmg_pkg::ST_DRAIN: begin
                if (!sts.pipe_busy) begin
                    state_next = wcmg_pkg::ST_FIN;
                end
            end
            // update total and load the output register once it is free
            wcmg_pkg::ST_FIN: begin
                if (sts.out_free) begin
                    cmd.fin    = 1'b1;
                    state_next = wcmg_pkg::ST_IDLE;
                end
            end
            // zero one covered mark per cycle
            wcmg_pkg::ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) begin
                    state_next = wcmg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wcmg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/wcmg_dpath.sv @@
// Datapath: weight tables, neighbour store, covered marks, gain and total.
`timescale 1ns / 1ps
`default_nettype none

module wcmg_dpath #(
    parameter int N_ELEM  = 256,
    parameter int M_ITEMS = 256,
    parameter int MAX_DEG = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire wcmg_pkg::cmd_t                   cmd,
    output wcmg_pkg::sts_t                        sts,
    input  wire logic [wcmg_pkg::ELEM_W-1:0]      in_elem,
    input  wire logic [wcmg_pkg::ITEM_W-1:0]      in_item,
    input  wire logic [wcmg_pkg::SLOT_W-1:0]      in_slot,
    input  wire logic [wcmg_pkg::COUNT_W-1:0]     in_count,
    input  wire logic signed [wcmg_pkg::VALUE_W-1:0] in_value,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [wcmg_pkg::GAIN_W-1:0]    m_gain,
    output logic signed [wcmg_pkg::TOTAL_W-1:0]   m_total
);

    localparam int EW    = N_ELEM > 1 ? $clog2(N_ELEM) : 1;
    localparam int IW    = M_ITEMS > 1 ? $clog2(M_ITEMS) : 1;
    localparam int EDEP  = N_ELEM * MAX_DEG;
    localparam int AW    = EDEP > 1 ? $clog2(EDEP) : 1;
    localparam int JW    = MAX_DEG > 1 ? $clog2(MAX_DEG) : 1;
    localparam int DW    = $clog2(MAX_DEG + 1);
    localparam int VW    = wcmg_pkg::VALUE_W;
    localparam int GW    = wcmg_pkg::GAIN_W;
    localparam int TW    = wcmg_pkg::TOTAL_W;

    // Input range checks
    logic in_elem_ok, in_item_ok, in_slot_ok;
    assign in_elem_ok = int'(in_elem) < N_ELEM;
    assign in_item_ok = int'(in_item) < M_ITEMS;
    assign in_slot_ok = int'(in_slot) < MAX_DEG;

    logic [EW-1:0] in_elem_idx;
    logic [AW-1:0] edge_waddr;
    logic [DW-1:0] deg_wdata;
    assign in_elem_idx = EW'(in_elem);
    assign edge_waddr  = AW'(AW'(in_elem) * AW'(MAX_DEG) + AW'(in_slot));
    assign deg_wdata   = (int'(in_count) > MAX_DEG) ? DW'(MAX_DEG) : DW'(in_count);

    // Captured element
    logic [EW-1:0] elem_reg;
    logic [AW-1:0] base_reg;
    logic          elem_ok_reg;

    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            elem_reg    <= in_elem_idx;
            base_reg    <= AW'(AW'(in_elem) * AW'(MAX_DEG));
            elem_ok_reg <= in_elem_ok;
        end
    end

    // Tables
    logic [VW-1:0]     mod_rdata, wgt_rdata;
    logic [DW-1:0]     deg_rdata;
    logic [wcmg_pkg::ITEM_W-1:0] edge_rdata;
    logic [JW-1:0]     j_reg;
    logic [AW-1:0]     edge_raddr;
    logic [IW-1:0]     nb_idx;

    assign edge_raddr = base_reg + AW'(j_reg);

    wcmg_ram #(.WIDTH(VW), .DEPTH(N_ELEM)) u_mod_ram (
        .aclk  (aclk),
        .we    (cmd.wr_mod && in_elem_ok),
        .waddr (in_elem_idx),
        .wdata (in_value),
        .raddr (elem_reg),
        .rdata (mod_rdata)
    );

    wcmg_ram #(.WIDTH(VW), .DEPTH(M_ITEMS)) u_wgt_ram (
        .aclk  (aclk),
        .we    (cmd.wr_wgt && in_item_ok),
        .waddr (IW'(in_item)),
        .wdata (in_value),
        .raddr (nb_idx),
        .rdata (wgt_rdata)
    );

    wcmg_ram #(.WIDTH(DW), .DEPTH(N_ELEM)) u_deg_ram (
        .aclk  (aclk),
        .we    (cmd.wr_deg && in_elem_ok),
        .waddr (in_elem_idx),
        .wdata (deg_wdata),
        .raddr (elem_reg),
        .rdata (deg_rdata)
    );

    wcmg_ram #(.WIDTH(wcmg_pkg::ITEM_W), .DEPTH(EDEP)) u_edge_ram (
        .aclk  (aclk),
        .we    (cmd.wr_edge && in_elem_ok && in_slot_ok),
        .waddr (edge_waddr),
        .wdata (in_item),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    // Walk counter and degree
    logic [DW-1:0] deg_reg;

    always_ff @(posedge aclk) begin
        if (cmd.hdr_ld) begin
            deg_reg <= deg_rdata;
            j_reg   <= '0;
        end else if (cmd.edge_rd) begin
            j_reg   <= j_reg + JW'(1);
        end
    end

    // Clear pointer over the covered marks
    logic [IW-1:0] clr_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg <= '0;
        end else if (cmd.clr) begin
            clr_idx_reg <= '0;
        end else if (cmd.clr_wr) begin
            clr_idx_reg <= clr_idx_reg + IW'(1);
        end
    end

    // Neighbour pipeline: edge data -> mark and weight read -> cover check and add
    logic              p1_reg, p2_reg, take;
    logic              nb_ok;
    logic [IW-1:0]     nb2_reg;
    logic              nb2_ok_reg;
    logic              prev_take_reg;
    logic [IW-1:0]     prev_nb_reg;
    logic              mark_rdata;

    assign nb_ok  = int'(edge_rdata) < M_ITEMS;
    assign nb_idx = IW'(edge_rdata);
    // a mark written last cycle is not yet visible in the read data
    assign take   = p2_reg && nb2_ok_reg && !mark_rdata &&
                    !(prev_take_reg && (prev_nb_reg == nb2_reg));

    wcmg_ram #(.WIDTH(1), .DEPTH(M_ITEMS)) u_mark_ram (
        .aclk  (aclk),
        .we    (cmd.clr_wr || take),
        .waddr (cmd.clr_wr ? clr_idx_reg : nb2_reg),
        .wdata (!cmd.clr_wr),
        .raddr (nb_idx),
        .rdata (mark_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            prev_take_reg <= 1'b0;
        end else begin
            p1_reg        <= cmd.edge_rd;
            p2_reg        <= p1_reg;
            prev_take_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        nb2_reg     <= nb_idx;
        nb2_ok_reg  <= nb_ok;
        prev_nb_reg <= nb2_reg;
    end

    // Gain accumulator
    logic signed [GW-1:0] gain_reg;

    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            gain_reg <= '0;
        end else if (cmd.hdr_ld) begin
            gain_reg <= GW'(signed'(mod_rdata));
        end else if (take) begin
            gain_reg <= gain_reg + GW'(signed'(wgt_rdata));
        end
    end

    // Running total with saturation
    logic signed [TW-1:0] total_reg;
    logic signed [TW:0]   total_sum;
    logic signed [TW-1:0] total_sat;

    assign total_sum = (TW+1)'(total_reg) + (TW+1)'(gain_reg);

    always_comb begin
        if (total_sum[TW] != total_sum[TW-1]) begin
            total_sat = total_sum[TW] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
        end else begin
            total_sat = total_sum[TW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
        end else if (cmd.clr) begin
            total_reg <= '0;
        end else if (cmd.fin && elem_ok_reg) begin
            total_reg <= total_sat;
        end
    end

    // Output register
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.fin) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin) begin
            m_gain  <= gain_reg;
            m_total <= elem_ok_reg ? total_sat : total_reg;
        end
    end

    assign m_valid = m_valid_reg;

    // Status
    assign sts.elem_ok   = elem_ok_reg;
    assign sts.deg_zero  = (deg_rdata == '0);
    assign sts.walk_last = (DW'(j_reg) == deg_reg - DW'(1));
    assign sts.pipe_busy = p1_reg || p2_reg;
    assign sts.out_free  = !m_valid_reg || m_ready;
    assign sts.clr_last  = (int'(clr_idx_reg) == M_ITEMS - 1);

`ifndef NO_ASSERTIONS
    a_fin_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin |-> !p1_reg && !p2_reg)
        else $error("result issued with neighbours still in flight");

    a_walk_nonzero_deg: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.edge_rd |-> deg_reg != '0)
        else $error("neighbour read with zero degree");

    a_bad_elem_zero_gain: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.fin && !elem_ok_reg) |-> gain_reg == '0)
        else $error("out of range element has nonzero gain");

    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_wr |-> !p1_reg && !p2_reg && !cmd.edge_rd)
        else $error("mark clear overlaps a neighbour walk");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/weighted_coverage_marginal_gain_unit.sv @@
// Top level of the weighted coverage marginal gain unit.
// Loads take effect at acceptance. An add captures the element, reads its header, walks
// its deg neighbours (one neighbour read a cycle; none for deg 0), drains, then updates
// the total and loads the output register, deg being the element's neighbour count.
// Throughput: one word at a time; loads every cycle, no new word during an add or start pass.
// Reset: synchronous active-low aresetn clears control and total; a pass then clears marks.
`timescale 1ns / 1ps
`default_nettype none

module weighted_coverage_marginal_gain_unit #(
    parameter int N_ELEM  = 256,
    parameter int M_ITEMS = 256,
    parameter int MAX_DEG = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // elem[7:0], item[15:8], slot[19:16], count[24:20], value[56:25], zero[63:57]
    input  wire logic [wcmg_pkg::S_DATA_W-1:0]     s_tdata,
    // kind[2:0]
    input  wire logic [wcmg_pkg::KIND_W-1:0]       s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // gain[39:0], total[87:40]
    output logic [wcmg_pkg::M_DATA_W-1:0]          m_tdata
);

    wcmg_pkg::cmd_t cmd;
    wcmg_pkg::sts_t sts;
    logic signed [wcmg_pkg::GAIN_W-1:0]  gain;
    logic signed [wcmg_pkg::TOTAL_W-1:0] total;

    wcmg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (wcmg_pkg::kind_t'(s_tuser)),
        .sts      (sts),
        .cmd      (cmd)
    );

    wcmg_dpath #(
        .N_ELEM  (N_ELEM),
        .M_ITEMS (M_ITEMS),
        .MAX_DEG (MAX_DEG)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .in_elem  (s_tdata[7:0]),
        .in_item  (s_tdata[15:8]),
        .in_slot  (s_tdata[19:16]),
        .in_count (s_tdata[24:20]),
        .in_value (s_tdata[56:25]),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_gain   (gain),
        .m_total  (total)
    );

    assign m_tdata = {total, gain};

endmodule

`default_nettype wire
